// ----- design/bllm_pkg.sv -----
package bllm_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_REMOVE_LAST = 3'd3;
  localparam op_t OP_REMOVE_AT  = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ----- design/bllm_ram.sv -----
module bllm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bounded_linked_list_manager.sv -----
// Singly linked list of up to CAPACITY signed values kept in a node store, with unused nodes
// chained on a free list. One request is taken at a time; each gives exactly one result with
// the removed value, a status and the new length. After reset the block chains the free list
// through the link memory and takes no request until that is done. Pushes and pop front pass
// through the execute state and a push or pop state to the result state; rejected requests go
// from the execute state straight to the result state. Remove last and remove at index follow
// the links one node per cycle through the link memory's read port; with the default store the
// slowest request is a remove at the last position of a full list. A finished result is held
// in an output register, so the next request can be accepted while it waits to be taken.
module bounded_linked_list_manager #(
  parameter int CAPACITY    = bllm_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bllm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bllm_pkg::OP_W-1:0]            in_operation,
  input  logic signed [bllm_pkg::DATA_W-1:0]   in_value,
  input  logic [bllm_pkg::POS_W-1:0]           in_position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [bllm_pkg::DATA_W-1:0]   out_removed_value,
  output logic [bllm_pkg::STATUS_W-1:0]        out_status,
  output logic [bllm_pkg::LEN_W-1:0]           out_length
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > bllm_pkg::POS_W) ? CW : bllm_pkg::POS_W;

  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_EXEC      = 4'd2;
  localparam logic [3:0] S_PUSH      = 4'd3;
  localparam logic [3:0] S_POP       = 4'd4;
  localparam logic [3:0] S_WALK      = 4'd5;
  localparam logic [3:0] S_STEP      = 4'd6;
  localparam logic [3:0] S_RMLAST    = 4'd7;
  localparam logic [3:0] S_VALRD     = 4'd8;
  localparam logic [3:0] S_AT_PREV   = 4'd9;
  localparam logic [3:0] S_AT_SEL    = 4'd10;
  localparam logic [3:0] S_AT_UNLINK = 4'd11;
  localparam logic [3:0] S_AT_FREE   = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [IW-1:0] init_idx_r, init_idx_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] free_r, free_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;

  bllm_pkg::op_t op_r, op_nxt;
  logic signed [bllm_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [bllm_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [IW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [IW-1:0] sel_r, sel_nxt;
  logic [bllm_pkg::DATA_W-1:0] res_val_r, res_val_nxt;
  bllm_pkg::status_t res_status_r, res_status_nxt;
  logic [bllm_pkg::DATA_W-1:0] out_val_r, out_val_nxt;
  bllm_pkg::status_t out_status_r, out_status_nxt;
  logic [bllm_pkg::LEN_W-1:0] out_len_r, out_len_nxt;

  logic link_we;
  logic [IW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
  logic val_we;
  logic [IW-1:0] val_waddr, val_raddr;
  logic [VALUE_WIDTH-1:0] val_wdata, val_rdata;

  logic signed [VALUE_WIDTH-1:0] val_rd_s;
  logic [63:0] val_wide;
  logic [bllm_pkg::DATA_W-1:0] removed;
  logic [CW-1:0] steps_dec;
  logic pos_bad;
  logic is_pop;

  bllm_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  bllm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  assign val_rd_s  = val_rdata;
  assign val_wide  = 64'(val_rd_s);
  assign removed   = val_wide[bllm_pkg::DATA_W-1:0];
  assign steps_dec = steps_r - CW'(1);
  assign pos_bad   = MW'(pos_r) >= MW'(count_r);
  assign is_pop    = (op_r == bllm_pkg::OP_POP_FRONT) ||
                     ((op_r == bllm_pkg::OP_REMOVE_AT) && (pos_r == '0));

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_removed_value = out_val_r;
  assign out_status        = out_status_r;
  assign out_length        = out_len_r;

  always_comb begin
    state_nxt      = state_r;
    init_idx_nxt   = init_idx_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_nxt       = free_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    cursor_nxt     = cursor_r;
    steps_nxt      = steps_r;
    sel_nxt        = sel_r;
    res_val_nxt    = res_val_r;
    res_status_nxt = res_status_r;
    out_val_nxt    = out_val_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    link_we        = 1'b0;
    link_waddr     = free_r;
    link_wdata     = free_r;
    link_raddr     = head_r;
    val_we         = 1'b0;
    val_waddr      = free_r;
    val_wdata      = VALUE_WIDTH'(64'(val_r));
    val_raddr      = head_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        link_we    = 1'b1;
        link_waddr = init_idx_r;
        link_wdata = (init_idx_r == IW'(CAPACITY - 1)) ? '0 : init_idx_r + IW'(1);
        init_idx_nxt = init_idx_r + IW'(1);
        if (init_idx_r == IW'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_operation;
          val_nxt   = in_value;
          pos_nxt   = in_position;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_val_nxt    = '0;
        res_status_nxt = bllm_pkg::ST_OK;
        cursor_nxt     = head_r;
        state_nxt      = S_DONE;
        if ((op_r == bllm_pkg::OP_PUSH_FRONT) || (op_r == bllm_pkg::OP_PUSH_BACK)) begin
          if (count_r == CW'(CAPACITY)) begin
            res_status_nxt = bllm_pkg::ST_FULL;
          end else begin
            link_raddr = free_r;
            state_nxt  = S_PUSH;
          end
        end else if (is_pop || ((op_r == bllm_pkg::OP_REMOVE_LAST) && (count_r == CW'(1)))) begin
          if (count_r == '0) begin
            res_status_nxt = bllm_pkg::ST_EMPTY;
          end else begin
            link_raddr = head_r;
            val_raddr  = head_r;
            state_nxt  = S_POP;
          end
        end else if (op_r == bllm_pkg::OP_REMOVE_LAST) begin
          if (count_r == '0) begin
            res_status_nxt = bllm_pkg::ST_EMPTY;
          end else begin
            steps_nxt = count_r - CW'(2);
            state_nxt = S_WALK;
          end
        end else if (op_r == bllm_pkg::OP_REMOVE_AT) begin
          if (pos_bad) begin
            res_status_nxt = bllm_pkg::ST_EMPTY;
          end else begin
            steps_nxt = CW'(pos_r - bllm_pkg::POS_W'(1));
            state_nxt = S_WALK;
          end
        end
      end
      S_PUSH: begin
        val_we    = 1'b1;
        val_waddr = free_r;
        free_nxt  = link_rdata;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
        if (count_r == '0) begin
          head_nxt = free_r;
          tail_nxt = free_r;
        end else if (op_r == bllm_pkg::OP_PUSH_FRONT) begin
          link_we    = 1'b1;
          link_waddr = free_r;
          link_wdata = head_r;
          head_nxt   = free_r;
        end else begin
          link_we    = 1'b1;
          link_waddr = tail_r;
          link_wdata = free_r;
          tail_nxt   = free_r;
        end
      end
      S_POP: begin
        res_val_nxt = removed;
        head_nxt    = link_rdata;
        link_we     = 1'b1;
        link_waddr  = head_r;
        link_wdata  = free_r;
        free_nxt    = head_r;
        count_nxt   = count_r - CW'(1);
        state_nxt   = S_DONE;
      end
      S_WALK: begin
        if (steps_r == '0) begin
          state_nxt = (op_r == bllm_pkg::OP_REMOVE_LAST) ? S_RMLAST : S_AT_PREV;
        end else begin
          link_raddr = cursor_r;
          state_nxt  = S_STEP;
        end
      end
      S_STEP: begin
        cursor_nxt = link_rdata;
        steps_nxt  = steps_dec;
        link_raddr = link_rdata;
        if (steps_dec == '0) begin
          state_nxt = (op_r == bllm_pkg::OP_REMOVE_LAST) ? S_RMLAST : S_AT_PREV;
        end
      end
      S_RMLAST: begin
        val_raddr  = tail_r;
        link_we    = 1'b1;
        link_waddr = tail_r;
        link_wdata = free_r;
        free_nxt   = tail_r;
        tail_nxt   = cursor_r;
        count_nxt  = count_r - CW'(1);
        state_nxt  = S_VALRD;
      end
      S_VALRD: begin
        res_val_nxt = removed;
        state_nxt   = S_DONE;
      end
      S_AT_PREV: begin
        link_raddr = cursor_r;
        state_nxt  = S_AT_SEL;
      end
      S_AT_SEL: begin
        sel_nxt    = link_rdata;
        link_raddr = link_rdata;
        val_raddr  = link_rdata;
        state_nxt  = S_AT_UNLINK;
      end
      S_AT_UNLINK: begin
        res_val_nxt = removed;
        link_we     = 1'b1;
        link_waddr  = cursor_r;
        link_wdata  = link_rdata;
        if (sel_r == tail_r) begin
          tail_nxt = cursor_r;
        end
        state_nxt = S_AT_FREE;
      end
      S_AT_FREE: begin
        link_we    = 1'b1;
        link_waddr = sel_r;
        link_wdata = free_r;
        free_nxt   = sel_r;
        count_nxt  = count_r - CW'(1);
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_val_nxt    = res_val_r;
          out_status_nxt = res_status_r;
          out_len_nxt    = bllm_pkg::LEN_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_idx_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      free_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_idx_r  <= init_idx_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    cursor_r     <= cursor_nxt;
    steps_r      <= steps_nxt;
    sel_r        <= sel_nxt;
    res_val_r    <= res_val_nxt;
    res_status_r <= res_status_nxt;
    out_val_r    <= out_val_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

endmodule

// ----- design/bllm_checker.sv -----
module bllm_checker #(
  parameter int CAPACITY = bllm_pkg::CAPACITY_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [bllm_pkg::DATA_W-1:0]        out_removed_value,
  input logic [bllm_pkg::STATUS_W-1:0]      out_status,
  input logic [bllm_pkg::LEN_W-1:0]         out_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_removed_value) &&
    $stable(out_status) && $stable(out_length))
    else $error("Result changed while stalled.");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bllm_pkg::ST_FULL) |->
    (out_length == bllm_pkg::LEN_W'(CAPACITY)) && (out_removed_value == '0))
    else $error("Full status without a full store.");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bllm_pkg::ST_EMPTY) |-> out_removed_value == '0)
    else $error("Failed removal returned a value.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bllm_pkg::ST_OK) || (out_status == bllm_pkg::ST_EMPTY) ||
    (out_status == bllm_pkg::ST_FULL))
    else $error("Undefined status code.");

endmodule

bind bounded_linked_list_manager bllm_checker #(.CAPACITY(CAPACITY)) u_bllm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_removed_value (out_removed_value),
  .out_status        (out_status),
  .out_length        (out_length)
);

// ----- tb/bounded_linked_list_manager_tb.sv -----
`timescale 1ns / 100ps

module bounded_linked_list_manager_tb;

  localparam int  CYCLE_LIMIT     = 1_000_000;
  localparam int  DRAIN_CYCLES    = bllm_pkg::CAPACITY_DEF + 16;
  localparam int  PHASE_REQUESTS  = 460;
  localparam bllm_pkg::op_t OP_FIRST_UNUSED = bllm_pkg::OP_REMOVE_AT + 3'd1;
  localparam bllm_pkg::op_t OP_LAST_UNUSED  = '1;

  typedef struct {
    logic signed [bllm_pkg::DATA_W-1:0] removed_value;
    bllm_pkg::status_t                  status;
    logic [bllm_pkg::LEN_W-1:0]         length;
  } list_reply_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  bllm_pkg::op_t                      in_operation = bllm_pkg::OP_PUSH_FRONT;
  logic signed [bllm_pkg::DATA_W-1:0] in_value = '0;
  logic [bllm_pkg::POS_W-1:0]         in_position = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [bllm_pkg::DATA_W-1:0] out_removed_value;
  bllm_pkg::status_t                  out_status;
  logic [bllm_pkg::LEN_W-1:0]         out_length;

  logic signed [bllm_pkg::DATA_W-1:0] shadow_list[$];
  list_reply_t                        awaited_replies[$];
  list_reply_t                        oldest_reply;
  int                                 send_idle_pct = 0;
  int                                 recv_stall_pct = 0;
  int                                 error_count = 0;
  int                                 cycle_count = 0;

  bounded_linked_list_manager DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_length        (out_length)
  );

  always #10 clk = ~clk;

  function automatic void compute_list_reply(input bllm_pkg::op_t op,
                                             input logic signed [bllm_pkg::DATA_W-1:0] val,
                                             input logic [bllm_pkg::POS_W-1:0] pos);
    list_reply_t reply;
    reply.removed_value = '0;
    reply.status        = bllm_pkg::ST_OK;
    case (op)
      bllm_pkg::OP_PUSH_FRONT, bllm_pkg::OP_PUSH_BACK: begin
        if (shadow_list.size() >= bllm_pkg::CAPACITY_DEF) begin
          reply.status = bllm_pkg::ST_FULL;
        end else if (op == bllm_pkg::OP_PUSH_FRONT) begin
          shadow_list.push_front(val);
        end else begin
          shadow_list.push_back(val);
        end
      end
      bllm_pkg::OP_POP_FRONT: begin
        if (shadow_list.size() == 0) begin
          reply.status = bllm_pkg::ST_EMPTY;
        end else begin
          reply.removed_value = shadow_list.pop_front();
        end
      end
      bllm_pkg::OP_REMOVE_LAST: begin
        if (shadow_list.size() == 0) begin
          reply.status = bllm_pkg::ST_EMPTY;
        end else begin
          reply.removed_value = shadow_list.pop_back();
        end
      end
      bllm_pkg::OP_REMOVE_AT: begin
        if (int'(pos) >= shadow_list.size()) begin
          reply.status = bllm_pkg::ST_EMPTY;
        end else begin
          reply.removed_value = shadow_list[pos];
          shadow_list.delete(pos);
        end
      end
      default: begin
      end
    endcase
    reply.length = bllm_pkg::LEN_W'(shadow_list.size());
    awaited_replies.push_back(reply);
  endfunction

  task automatic send_request(input bllm_pkg::op_t op,
                              input logic signed [bllm_pkg::DATA_W-1:0] val,
                              input logic [bllm_pkg::POS_W-1:0] pos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    in_position  <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    compute_list_reply(op, val, pos);
  endtask

  task automatic send_random_request(input int push_pct);
    int                                 roll;
    bllm_pkg::op_t                      op;
    logic signed [bllm_pkg::DATA_W-1:0] val;
    logic [bllm_pkg::POS_W-1:0]         pos;
    roll = $urandom_range(99);
    val  = $urandom;
    if ($urandom_range(9) == 0) begin
      val = ($urandom_range(1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end
    pos = bllm_pkg::POS_W'($urandom_range(15));
    if (roll < 3) begin
      op = bllm_pkg::op_t'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    end else if (roll < 3 + push_pct) begin
      op = ($urandom_range(1) == 0) ? bllm_pkg::OP_PUSH_FRONT : bllm_pkg::OP_PUSH_BACK;
    end else begin
      case ($urandom_range(2))
        0:       op = bllm_pkg::OP_POP_FRONT;
        1:       op = bllm_pkg::OP_REMOVE_LAST;
        default: op = bllm_pkg::OP_REMOVE_AT;
      endcase
    end
    if (op == bllm_pkg::OP_REMOVE_AT && shadow_list.size() > 0 && $urandom_range(4) != 0) begin
      pos = bllm_pkg::POS_W'($urandom_range(shadow_list.size() - 1));
    end
    send_request(op, val, pos);
  endtask

  task automatic test_empty_list;
    send_request(bllm_pkg::OP_POP_FRONT, 32'sh1234_5678, '0);
    send_request(bllm_pkg::OP_REMOVE_LAST, '0, '1);
    send_request(bllm_pkg::OP_REMOVE_AT, '0, '0);
    send_request(bllm_pkg::OP_REMOVE_AT, -1, 4'd15);
  endtask

  task automatic test_unknown_operations;
    for (int n = OP_FIRST_UNUSED; n <= OP_LAST_UNUSED; n++) begin
      send_request(bllm_pkg::op_t'(n), $urandom, bllm_pkg::POS_W'($urandom));
    end
  endtask

  task automatic test_single_element;
    send_request(bllm_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF, '0);
    send_request(bllm_pkg::OP_REMOVE_LAST, '0, '0);
  endtask

  task automatic test_full_store;
    send_request(bllm_pkg::OP_PUSH_FRONT, 32'sh8000_0000, '0);
    send_request(bllm_pkg::OP_PUSH_BACK, '0, '1);
    for (int n = 2; n < bllm_pkg::CAPACITY_DEF; n++) begin
      send_request(n[0] ? bllm_pkg::OP_PUSH_BACK : bllm_pkg::OP_PUSH_FRONT, $urandom,
                   bllm_pkg::POS_W'($urandom));
    end
    send_request(bllm_pkg::OP_PUSH_FRONT, -1, '0);
    send_request(bllm_pkg::OP_PUSH_BACK, 32'sh7FFF_FFFF, '0);
    send_request(bllm_pkg::OP_REMOVE_AT, '0, 4'd15);
  endtask

  task automatic run_traffic_phase(input int idle_pct, input int stall_pct);
    int push_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    push_pct       = 50;
    for (int n = 0; n < PHASE_REQUESTS; n++) begin
      // The push share drifts so that the list sweeps between empty and full.
      if (n % 40 == 0) push_pct = $urandom_range(80, 15);
      send_random_request(push_pct);
    end
  endtask

  task automatic test_random_traffic;
    run_traffic_phase(0, 0);
    run_traffic_phase(55, 0);
    run_traffic_phase(0, 55);
    run_traffic_phase(34, 34);
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        $error("unexpected result: removed_value %0d status %0d length %0d",
               out_removed_value, out_status, out_length);
        error_count++;
      end else begin
        oldest_reply = awaited_replies.pop_front();
        if (out_removed_value !== oldest_reply.removed_value) begin
          $error("removed_value expected %0d actual %0d",
                 oldest_reply.removed_value, out_removed_value);
          error_count++;
        end
        if (out_status !== oldest_reply.status) begin
          $error("status expected %0d actual %0d", oldest_reply.status, out_status);
          error_count++;
        end
        if (out_length !== oldest_reply.length) begin
          $error("length expected %0d actual %0d", oldest_reply.length, out_length);
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_unknown_operations();
    test_single_element();
    test_full_store();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
